### design/rpd_pkg.sv
// ----------------------------------------------------------------------------
// rpd_pkg
// Types and character codes shared by the run-length pattern decoder.
// ----------------------------------------------------------------------------
package rpd_pkg;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_BLANK  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_B = 8'h62;
	localparam logic [7:0] CH_LOWER_O = 8'h6F;

	localparam int unsigned COUNT_BITS = 16;
	localparam int unsigned OUT_BITS   = 16;
	localparam int unsigned CFG_BITS   = 16;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	localparam logic REG_X_OFFSET = 1'b0;
	localparam logic REG_Y_OFFSET = 1'b1;

	localparam logic KIND_RUN = 1'b0;
	localparam logic KIND_END = 1'b1;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_DIGIT,
		ACT_SKIP,
		ACT_RUN,
		ACT_ROW,
		ACT_CLEAR,
		ACT_END
	} action_t;

	typedef struct packed {
		action_t    action;
		logic [3:0] digit;
		logic [4:0] value;
	} cmd_t;

	typedef struct packed {
		logic                kind;
		logic [OUT_BITS-1:0] x_start;
		logic [OUT_BITS-1:0] row_out;
		logic [OUT_BITS-1:0] run_length;
		logic [4:0]          cell_value;
	} result_t;

endpackage

### design/rpd_char_if.sv
// ----------------------------------------------------------------------------
// rpd_char_if
// Character channel: one pattern character per word.
// ----------------------------------------------------------------------------
interface rpd_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       stream_end;
	logic [3:0] random_color;

	modport source(output valid, output char_code, output stream_end,
		output random_color, input ready);
	modport sink(input valid, input char_code, input stream_end,
		input random_color, output ready);
endinterface

### design/rpd_run_if.sv
// ----------------------------------------------------------------------------
// rpd_run_if
// Result channel: one cell run or end marker per word.
// ----------------------------------------------------------------------------
interface rpd_run_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] x_start;
	logic [15:0] row_out;
	logic [15:0] run_length;
	logic [4:0]  cell_value;

	modport source(output valid, output kind, output x_start, output row_out,
		output run_length, output cell_value, input ready);
	modport sink(input valid, input kind, input x_start, input row_out,
		input run_length, input cell_value, output ready);
endinterface

### design/rpd_classify.sv
// ----------------------------------------------------------------------------
// rpd_classify
// Sorts an incoming character into the action it takes on the decoder state.
// ----------------------------------------------------------------------------
module rpd_classify (
	input  logic [7:0]   char_code,
	input  logic         stream_end,
	input  logic [3:0]   random_color,
	output rpd_pkg::cmd_t cmd
);

	always_comb begin
		cmd.digit  = char_code[3:0];
		cmd.value  = 5'd0;
		cmd.action = rpd_pkg::ACT_CLEAR;
		if (stream_end || char_code == rpd_pkg::CH_BANG || char_code == rpd_pkg::CH_NUL) begin
			cmd.action = rpd_pkg::ACT_END;
		end else if (char_code == rpd_pkg::CH_BLANK || char_code == rpd_pkg::CH_LF
			|| char_code == rpd_pkg::CH_TAB) begin
			cmd.action = rpd_pkg::ACT_NONE;
		end else if (char_code >= rpd_pkg::CH_ZERO && char_code <= rpd_pkg::CH_NINE) begin
			cmd.action = rpd_pkg::ACT_DIGIT;
		end else if (char_code == rpd_pkg::CH_LOWER_B || char_code == rpd_pkg::CH_DOT) begin
			cmd.action = rpd_pkg::ACT_SKIP;
		end else if (char_code == rpd_pkg::CH_LOWER_O) begin
			cmd.action = rpd_pkg::ACT_RUN;
			cmd.value  = {1'b0, random_color};
		end else if (char_code >= rpd_pkg::CH_UPPER_A && char_code <= rpd_pkg::CH_UPPER_Z) begin
			// low five bits of 'A'..'Z' are 1..26
			cmd.action = rpd_pkg::ACT_RUN;
			cmd.value  = char_code[4:0];
		end else if (char_code == rpd_pkg::CH_DOLLAR) begin
			cmd.action = rpd_pkg::ACT_ROW;
		end
	end

endmodule

### design/rpd_position.sv
// ----------------------------------------------------------------------------
// rpd_position
// Run count, column and row registers, offset registers, and the result
// built from them for the current command.
// ----------------------------------------------------------------------------
module rpd_position #(
	parameter int unsigned COORD_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rpd_pkg::cmd_t                   cmd,
	input  logic                            fire,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [rpd_pkg::CFG_BITS-1:0]    cfg_data,
	output logic                            emit,
	output rpd_pkg::result_t                result
);

	localparam int unsigned CB = rpd_pkg::COUNT_BITS;
	localparam int unsigned OB = rpd_pkg::OUT_BITS;

	logic [CB-1:0]          count_q;
	logic [COORD_BITS-1:0]  column_q;
	logic [COORD_BITS-1:0]  row_q;
	logic [rpd_pkg::CFG_BITS-1:0] x_off_q;
	logic [rpd_pkg::CFG_BITS-1:0] y_off_q;

	logic [CB-1:0]               n;
	logic [CB+3:0]               count_next;
	logic [CB-1:0]               count_sat;
	logic [COORD_BITS+CB-1:0]    n_ext;
	logic [COORD_BITS+15:0]      xo_ext;
	logic [COORD_BITS+15:0]      yo_ext;
	logic [COORD_BITS+15:0]      cfg_ext;
	logic [COORD_BITS+OB-1:0]    col_ext;
	logic [COORD_BITS+OB-1:0]    row_ext;
	logic [COORD_BITS-1:0]       x_home;
	logic [COORD_BITS-1:0]       y_home;
	logic [COORD_BITS-1:0]       cfg_coord;
	logic [COORD_BITS-1:0]       column_adv;
	logic [COORD_BITS-1:0]       row_adv;

	assign n          = (count_q == '0) ? CB'(1) : count_q;
	assign count_next = {1'b0, count_q, 3'b000} + {3'b000, count_q, 1'b0}
		+ {{CB{1'b0}}, cmd.digit};
	assign count_sat  = (count_next > {4'b0000, rpd_pkg::COUNT_MAX})
		? rpd_pkg::COUNT_MAX : count_next[CB-1:0];

	assign n_ext      = {{COORD_BITS{1'b0}}, n};
	assign xo_ext     = {{COORD_BITS{1'b0}}, x_off_q};
	assign yo_ext     = {{COORD_BITS{1'b0}}, y_off_q};
	assign cfg_ext    = {{COORD_BITS{1'b0}}, cfg_data};
	assign x_home     = xo_ext[COORD_BITS-1:0];
	assign y_home     = yo_ext[COORD_BITS-1:0];
	assign cfg_coord  = cfg_ext[COORD_BITS-1:0];
	assign column_adv = column_q + n_ext[COORD_BITS-1:0];
	assign row_adv    = row_q + n_ext[COORD_BITS-1:0];
	assign col_ext    = {{OB{1'b0}}, column_q};
	assign row_ext    = {{OB{1'b0}}, row_q};

	always_comb begin
		emit              = 1'b0;
		result.kind       = rpd_pkg::KIND_RUN;
		result.x_start    = '0;
		result.row_out    = '0;
		result.run_length = '0;
		result.cell_value = 5'd0;
		case (cmd.action)
			rpd_pkg::ACT_RUN: begin
				emit              = 1'b1;
				result.x_start    = col_ext[OB-1:0];
				result.row_out    = row_ext[OB-1:0];
				result.run_length = n;
				result.cell_value = cmd.value;
			end
			rpd_pkg::ACT_END: begin
				emit        = 1'b1;
				result.kind = rpd_pkg::KIND_END;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			column_q <= '0;
			row_q    <= '0;
			x_off_q  <= '0;
			y_off_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rpd_pkg::REG_X_OFFSET: begin
					x_off_q  <= cfg_data;
					column_q <= cfg_coord;
				end
				rpd_pkg::REG_Y_OFFSET: begin
					y_off_q <= cfg_data;
					row_q   <= cfg_coord;
				end
				default: begin
					x_off_q <= x_off_q;
				end
			endcase
		end else if (fire) begin
			case (cmd.action)
				rpd_pkg::ACT_NONE: begin
					count_q <= count_q;
				end
				rpd_pkg::ACT_DIGIT: begin
					count_q <= count_sat;
				end
				rpd_pkg::ACT_SKIP, rpd_pkg::ACT_RUN: begin
					count_q  <= '0;
					column_q <= column_adv;
				end
				rpd_pkg::ACT_ROW: begin
					count_q  <= '0;
					row_q    <= row_adv;
					column_q <= x_home;
				end
				rpd_pkg::ACT_END: begin
					count_q  <= '0;
					column_q <= x_home;
					row_q    <= y_home;
				end
				default: begin
					count_q <= '0;
				end
			endcase
		end
	end

endmodule

### design/rle_pattern_decoder.sv
// ----------------------------------------------------------------------------
// rle_pattern_decoder
// Run-length cell pattern decoder: characters in, cell runs and end markers out.
// ----------------------------------------------------------------------------
// Takes one character word per cycle while the result side is not stalled,
// and returns at most one result word per character. Each accepted
// character is classified and registered, then the run count, column and
// row update and a result register holds the word for the sink. While it
// waits, characters that yield no result still pass, and the input stalls
// once a character that yields one is held. Offset writes load column and
// row; they are to be made while idle, and the block does not enforce this.
module rle_pattern_decoder #(
	parameter int unsigned COORD_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	rpd_char_if.sink                     chars,
	rpd_run_if.source                    runs,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [rpd_pkg::CFG_BITS-1:0] cfg_data
);

	rpd_pkg::cmd_t    cmd_in;
	rpd_pkg::cmd_t    cmd_s1;
	logic             valid_s1;
	logic             emit;
	logic             fire;
	logic             out_free;
	rpd_pkg::result_t result;
	rpd_pkg::result_t res_q;
	logic             res_valid_q;

	rpd_classify u_classify (
		.char_code   (chars.char_code),
		.stream_end  (chars.stream_end),
		.random_color(chars.random_color),
		.cmd         (cmd_in)
	);

	rpd_position #(
		.COORD_BITS(COORD_BITS)
	) u_position (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd_s1),
		.fire     (fire),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.emit     (emit),
		.result   (result)
	);

	assign out_free    = !res_valid_q || runs.ready;
	assign fire        = valid_s1 && (!emit || out_free);
	assign chars.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.ready && chars.valid) begin
			cmd_s1 <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= fire && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			res_q <= result;
		end
	end

	assign runs.valid      = res_valid_q;
	assign runs.kind       = res_q.kind;
	assign runs.x_start    = res_q.x_start;
	assign runs.row_out    = res_q.row_out;
	assign runs.run_length = res_q.run_length;
	assign runs.cell_value = res_q.cell_value;

endmodule

### test/rpd_run_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rpd_run_checker
// Watches the character, result and offset ports of the pattern decoder.
// ----------------------------------------------------------------------------
// Every accepted character word is decoded here against a private copy of the
// run count, column, row and offsets, and the run or end marker that it yields
// is queued. Each accepted result word is compared field by field with the
// oldest queued one. Mismatches and the number of result words still due are
// handed to the testbench top.
module rpd_run_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	rpd_char_if                          chars,
	rpd_run_if                           runs,
	input  logic                         cfg_we,
	input  logic                         cfg_index,
	input  logic [rpd_pkg::CFG_BITS-1:0] cfg_data,
	output int unsigned                  mismatches,
	output int unsigned                  runs_due
);

	localparam int unsigned CB = rpd_pkg::COUNT_BITS;

	rpd_pkg::result_t expected_runs[$];

	logic [CB-1:0] run_count;
	logic [15:0]   column;
	logic [15:0]   row;
	logic [15:0]   x_off;
	logic [15:0]   y_off;

	function automatic void decode_char(input logic [7:0] code, input logic last,
		input logic [3:0] color);
		logic [31:0]      grown;
		logic [CB-1:0]    len;
		rpd_pkg::result_t run;
		run = '0;
		if (last || code == rpd_pkg::CH_BANG || code == rpd_pkg::CH_NUL) begin
			run.kind = rpd_pkg::KIND_END;
			expected_runs.push_back(run);
			run_count = '0;
			column = x_off;
			row = y_off;
			return;
		end
		if (code == rpd_pkg::CH_BLANK || code == rpd_pkg::CH_TAB
			|| code == rpd_pkg::CH_LF)
			return;
		if (code >= rpd_pkg::CH_ZERO && code <= rpd_pkg::CH_NINE) begin
			grown = 32'(run_count) * 32'd10 + 32'(code - rpd_pkg::CH_ZERO);
			run_count = (grown > 32'(rpd_pkg::COUNT_MAX))
				? rpd_pkg::COUNT_MAX : grown[CB-1:0];
			return;
		end
		len = (run_count == '0) ? CB'(1) : run_count;
		run_count = '0;
		if (code == rpd_pkg::CH_LOWER_B || code == rpd_pkg::CH_DOT) begin
			column = column + len;
		end else if (code == rpd_pkg::CH_LOWER_O
			|| (code >= rpd_pkg::CH_UPPER_A && code <= rpd_pkg::CH_UPPER_Z)) begin
			run.kind = rpd_pkg::KIND_RUN;
			run.x_start = column;
			run.row_out = row;
			run.run_length = len;
			run.cell_value = (code == rpd_pkg::CH_LOWER_O) ? {1'b0, color}
				: 5'(code - rpd_pkg::CH_UPPER_A + 8'd1);
			expected_runs.push_back(run);
			column = column + len;
		end else if (code == rpd_pkg::CH_DOLLAR) begin
			row = row + len;
			column = x_off;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rpd_pkg::result_t due;
		if (!arst_n) begin
			expected_runs.delete();
			run_count = '0;
			x_off = '0;
			y_off = '0;
			column = '0;
			row = '0;
			mismatches = 0;
			runs_due = 0;
		end else begin
			if (runs.valid && runs.ready) begin
				if (expected_runs.size() == 0) begin
					$error("result word with nothing expected: kind %0d x %0d row %0d",
						runs.kind, runs.x_start, runs.row_out);
					mismatches++;
				end else begin
					due = expected_runs.pop_front();
					if (runs.kind !== due.kind) begin
						$error("kind: expected %0d, got %0d", due.kind, runs.kind);
						mismatches++;
					end
					if (runs.x_start !== due.x_start) begin
						$error("x_start: expected %0d, got %0d", due.x_start, runs.x_start);
						mismatches++;
					end
					if (runs.row_out !== due.row_out) begin
						$error("row_out: expected %0d, got %0d", due.row_out, runs.row_out);
						mismatches++;
					end
					if (runs.run_length !== due.run_length) begin
						$error("run_length: expected %0d, got %0d", due.run_length,
							runs.run_length);
						mismatches++;
					end
					if (runs.cell_value !== due.cell_value) begin
						$error("cell_value: expected %0d, got %0d", due.cell_value,
							runs.cell_value);
						mismatches++;
					end
				end
			end
			if (cfg_we) begin
				if (cfg_index == rpd_pkg::REG_X_OFFSET) begin
					x_off = cfg_data;
					column = cfg_data;
				end else begin
					y_off = cfg_data;
					row = cfg_data;
				end
			end
			if (chars.valid && chars.ready)
				decode_char(chars.char_code, chars.stream_end, chars.random_color);
			runs_due = expected_runs.size();
		end
	end

endmodule

### test/tb_rle_pattern_decoder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rle_pattern_decoder
// Stimulus and verdict for the run-length pattern decoder.
// ----------------------------------------------------------------------------
// A short directed pass covers every character class, zero and saturated
// counts, color extremes, high bytes and the three ways to end a pattern.
// The random pass sends mostly well-formed pattern text with noise mixed in,
// and reloads the offsets between phases, extremes included. The sender
// works in bursts, the receiver stalls in changing patterns and once holds
// off long enough to back up the input. A checker beside the block predicts
// and compares every result word.
module tb_rle_pattern_decoder;

	localparam int unsigned RANDOM_ITEMS  = 700;
	localparam int unsigned PHASE_ITEMS   = 150;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES   = 300;

	typedef enum int unsigned {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         cfg_we;
	logic                         cfg_index;
	logic [rpd_pkg::CFG_BITS-1:0] cfg_data;
	int unsigned                  mismatches;
	int unsigned                  runs_due;
	int unsigned                  items_sent;
	int unsigned                  burst_left;
	bit                           hold_req;
	bit                           hold_done;

	rpd_char_if chars_bus();
	rpd_run_if  runs_bus();

	rle_pattern_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars_bus),
		.runs     (runs_bus),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	rpd_run_checker checker_inst (
		.clk       (clk),
		.arst_n    (arst_n),
		.chars     (chars_bus),
		.runs      (runs_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.mismatches(mismatches),
		.runs_due  (runs_due)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

	task automatic send_char(input logic [7:0] code, input logic last, input logic [3:0] color);
		int unsigned gap;
		chars_bus.valid <= 1'b1;
		chars_bus.char_code <= code;
		chars_bus.stream_end <= last;
		chars_bus.random_color <= color;
		@(posedge clk);
		while (!chars_bus.ready) @(posedge clk);
		@(negedge clk);
		if (!(code == rpd_pkg::CH_BLANK || code == rpd_pkg::CH_TAB
			|| code == rpd_pkg::CH_LF) || last)
			items_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
				: $urandom_range(0, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				chars_bus.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
	endtask

	task automatic send_text(input string text);
		for (int i = 0; i < text.len(); i++)
			send_char(8'(text[i]), 1'b0, 4'($urandom));
	endtask

	// wait until every result word is back and nothing is left in flight
	task automatic drain();
		chars_bus.valid <= 1'b0;
		while (runs_due != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_offsets(input logic [15:0] x, input logic [15:0] y);
		cfg_we <= 1'b1;
		cfg_index <= rpd_pkg::REG_X_OFFSET;
		cfg_data <= x;
		@(negedge clk);
		cfg_index <= rpd_pkg::REG_Y_OFFSET;
		cfg_data <= y;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_count();
		int unsigned pick;
		pick = $urandom_range(0, 19);
		if (pick < 6)
			return;
		if ($urandom_range(0, 7) == 0)
			send_text("0");
		if (pick < 16)
			send_text($sformatf("%0d", $urandom_range(0, 9)));
		else if (pick < 19)
			send_text($sformatf("%0d", $urandom_range(10, 999)));
		else
			send_text($sformatf("%0d", $urandom_range(10000, 999999)));
	endtask

	task automatic send_token();
		int unsigned pick;
		logic [7:0]  code;
		pick = $urandom_range(0, 99);
		if (pick < 45) begin
			send_count();
			code = ($urandom_range(0, 2) == 0) ? rpd_pkg::CH_LOWER_O
				: 8'(rpd_pkg::CH_UPPER_A + $urandom_range(0, 25));
			send_char(code, 1'b0, 4'($urandom));
		end else if (pick < 65) begin
			send_count();
			send_char(($urandom_range(0, 1) == 0) ? rpd_pkg::CH_LOWER_B : rpd_pkg::CH_DOT,
				1'b0, 4'($urandom));
		end else if (pick < 75) begin
			send_count();
			send_char(rpd_pkg::CH_DOLLAR, 1'b0, 4'($urandom));
		end else if (pick < 80) begin
			case ($urandom_range(0, 2))
				0: send_char(rpd_pkg::CH_BLANK, 1'b0, 4'($urandom));
				1: send_char(rpd_pkg::CH_TAB, 1'b0, 4'($urandom));
				default: send_char(rpd_pkg::CH_LF, 1'b0, 4'($urandom));
			endcase
		end else if (pick < 85) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: send_char(rpd_pkg::CH_BANG, 1'b0, 4'($urandom));
				5, 6: send_char(rpd_pkg::CH_NUL, 1'b0, 4'($urandom));
				default: send_char(8'($urandom), 1'b1, 4'($urandom));
			endcase
		end else begin
			if ($urandom_range(0, 1) == 0)
				send_count();
			send_char(8'($urandom), ($urandom_range(0, 15) == 0), 4'($urandom));
		end
	endtask

	initial begin
		rx_mode_t    mode;
		int unsigned stretch;
		runs_bus.ready = 1'b0;
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			stretch = $urandom_range(8, 64);
			repeat (stretch) begin
				@(negedge clk);
				if (hold_req && !hold_done) begin
					hold_done = 1'b1;
					runs_bus.ready <= 1'b0;
					repeat (HOLD_CYCLES) @(negedge clk);
				end else begin
					case (mode)
						RX_OPEN: runs_bus.ready <= 1'b1;
						RX_COIN: runs_bus.ready <= 1'($urandom);
						RX_SPARSE: runs_bus.ready <= ($urandom_range(0, 3) == 0);
						default: runs_bus.ready <= !runs_bus.ready;
					endcase
				end
			end
		end
	end

	initial begin
		int unsigned phase;
		int unsigned next_phase;
		logic [15:0] base;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = rpd_pkg::REG_X_OFFSET;
		cfg_data = '0;
		chars_bus.valid = 1'b0;
		chars_bus.char_code = '0;
		chars_bus.stream_end = 1'b0;
		chars_bus.random_color = '0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		burst_left = 0;
		items_sent = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_char(rpd_pkg::CH_LOWER_O, 1'b0, 4'h0);
		send_text("3");
		send_char(rpd_pkg::CH_LOWER_O, 1'b0, 4'hF);
		send_text("0A2b.Z12$\t \n5x");
		send_char(8'hFF, 1'b0, 4'h8);
		send_text("7");
		send_char(8'h80, 1'b0, 4'h1);
		send_text("o99999o!4");
		send_char(rpd_pkg::CH_NUL, 1'b0, 4'h5);
		send_text("2");
		send_char(rpd_pkg::CH_LOWER_O, 1'b1, 4'hA);
		drain();
		write_offsets(16'hFFFE, 16'hFFFF);
		send_text("3o$2A65535b.o!");
		drain();
		write_offsets(16'h0000, 16'h0000);

		items_sent = 0;
		phase = 0;
		next_phase = PHASE_ITEMS;
		while (items_sent < RANDOM_ITEMS) begin
			if (!hold_req && items_sent >= 200)
				hold_req = 1'b1;
			if (items_sent >= next_phase) begin
				drain();
				base = 16'($urandom);
				case (phase % 4)
					0: write_offsets(16'hFFFF, 16'hFFFF);
					1: write_offsets(base, 16'($urandom));
					2: write_offsets(16'h0000, 16'h0000);
					default: write_offsets(16'hFFF0 | base[3:0], 16'hFFF8 | base[7:4]);
				endcase
				phase++;
				next_phase += PHASE_ITEMS;
			end
			send_token();
		end
		send_char(rpd_pkg::CH_BANG, 1'b0, 4'($urandom));

		chars_bus.valid <= 1'b0;
		while (runs_due != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatches == 0 && runs_due == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
